@@ sv/tccr_pkg.sv @@
// Shared types, codes and color tables for the terminal cell color resolver.
// No dependencies; every other file in this block imports this package.
package tccr_pkg;

  localparam int ColorWidth = 24;
  localparam int CodeWidth  = 21;

  localparam logic [1:0] KIND_DEFAULT = 2'd0;
  localparam logic [1:0] KIND_INDEXED = 2'd1;
  localparam logic [1:0] KIND_DIRECT  = 2'd2;

  localparam logic CFG_DEFAULT_FG = 1'b0;
  localparam logic CFG_DEFAULT_BG = 1'b1;

  localparam logic [ColorWidth-1:0] DefaultFgReset = 24'hC8C8C8;
  localparam logic [ColorWidth-1:0] DefaultBgReset = 24'h000000;

  localparam logic [CodeWidth-1:0] CodeNull  = 21'h000000;
  localparam logic [CodeWidth-1:0] CodeSpace = 21'h000020;

  typedef enum logic [1:0] {
    PAL_FIXED,
    PAL_CUBE,
    PAL_GREY
  } palette_class_t;

  typedef struct packed {
    logic [1:0]            fg_kind;
    logic [7:0]            fg_index;
    logic [ColorWidth-1:0] fg_direct;
    logic [1:0]            bg_kind;
    logic [7:0]            bg_index;
    logic [ColorWidth-1:0] bg_direct;
    logic [7:0]            attr_low;
    logic                  is_wide_tail;
    logic                  is_reverse;
    logic                  is_invisible;
    logic [CodeWidth-1:0]  code_point;
  } cell_word_t;

  typedef struct packed {
    logic [ColorWidth-1:0] fg_color;
    logic [ColorWidth-1:0] bg_color;
    logic [7:0]            attr_out;
    logic                  glyph_wanted;
    logic [CodeWidth-1:0]  code_point_out;
  } result_word_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  function automatic logic [ColorWidth-1:0] fixed_color(input logic [3:0] idx);
    logic [ColorWidth-1:0] col;
    case (idx)
      4'd0:    col = 24'h000000;
      4'd1:    col = 24'hCD0000;
      4'd2:    col = 24'h00CD00;
      4'd3:    col = 24'hCDCD00;
      4'd4:    col = 24'h0000EE;
      4'd5:    col = 24'hCD00CD;
      4'd6:    col = 24'h00CDCD;
      4'd7:    col = 24'hE5E5E5;
      4'd8:    col = 24'h7F7F7F;
      4'd9:    col = 24'hFF0000;
      4'd10:   col = 24'h00FF00;
      4'd11:   col = 24'hFFFF00;
      4'd12:   col = 24'h5C5CFF;
      4'd13:   col = 24'hFF00FF;
      4'd14:   col = 24'h00FFFF;
      default: col = 24'hFFFFFF;
    endcase
    return col;
  endfunction

  function automatic logic [7:0] cube_level(input logic [2:0] digit);
    logic [7:0] lvl;
    case (digit)
      3'd0:    lvl = 8'd0;
      3'd1:    lvl = 8'd95;
      3'd2:    lvl = 8'd135;
      3'd3:    lvl = 8'd175;
      3'd4:    lvl = 8'd215;
      3'd5:    lvl = 8'd255;
      default: lvl = 8'd0;
    endcase
    return lvl;
  endfunction

endpackage

@@ sv/tccr_color_pipe.sv @@
// Resolves one color (default, direct or xterm 256 palette) over two register
// stages and a final selection. Depends on tccr_pkg.
module tccr_color_pipe import tccr_pkg::*; (
  input  logic                  clk,
  input  stage_en_t             en,
  input  logic [1:0]            kind,
  input  logic [7:0]            index,
  input  logic [ColorWidth-1:0] direct,
  input  logic [ColorWidth-1:0] dflt,
  output logic [ColorWidth-1:0] color
);

  logic [1:0]            kind1;
  logic [7:0]            idx1;
  logic [ColorWidth-1:0] direct1;
  palette_class_t        cls1;
  logic [2:0]            r1;
  logic [5:0]            rem1;

  logic [1:0]            kind2;
  logic [ColorWidth-1:0] direct2;
  palette_class_t        cls2;
  logic [ColorWidth-1:0] fixed2;
  logic [2:0]            r2;
  logic [2:0]            g2;
  logic [2:0]            b2;
  logic [7:0]            grey2;

  logic [7:0]     cube_off;
  logic [13:0]    r_prod;
  logic [2:0]     r_digit;
  logic [7:0]     rem_full;
  palette_class_t cls_next;
  logic [11:0]    g_prod;
  logic [2:0]     g_digit;
  logic [5:0]     b_full;
  logic [7:0]     grey_off;
  logic [7:0]     grey_lvl;

  // Cube digits come from multiplying by a scaled reciprocal of 36 and of 6.
  always_comb begin
    cube_off = index - 8'd16;
    r_prod   = {6'b0, cube_off} * 14'd57;
    r_digit  = r_prod[13:11];
    rem_full = cube_off - ({5'b0, r_digit} * 8'd36);
    if (index < 8'd16) begin
      cls_next = PAL_FIXED;
    end else if (index < 8'd232) begin
      cls_next = PAL_CUBE;
    end else begin
      cls_next = PAL_GREY;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      kind1   <= kind;
      idx1    <= index;
      direct1 <= direct;
      cls1    <= cls_next;
      r1      <= r_digit;
      rem1    <= rem_full[5:0];
    end
  end

  always_comb begin
    g_prod   = {6'b0, rem1} * 12'd43;
    g_digit  = g_prod[10:8];
    b_full   = rem1 - ({3'b0, g_digit} * 6'd6);
    grey_off = idx1 - 8'd232;
    grey_lvl = 8'd8 + ({3'b0, grey_off[4:0]} * 8'd10);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      kind2   <= kind1;
      direct2 <= direct1;
      cls2    <= cls1;
      fixed2  <= fixed_color(idx1[3:0]);
      r2      <= r1;
      g2      <= g_digit;
      b2      <= b_full[2:0];
      grey2   <= grey_lvl;
    end
  end

  always_comb begin
    case (kind2)
      KIND_INDEXED: begin
        unique case (cls2)
          PAL_FIXED: color = fixed2;
          PAL_CUBE:  color = {cube_level(r2), cube_level(g2), cube_level(b2)};
          PAL_GREY:  color = {grey2, grey2, grey2};
          default:   color = fixed2;
        endcase
      end
      KIND_DIRECT: color = direct2;
      default:     color = dflt;
    endcase
  end

endmodule

@@ sv/terminal_cell_color_resolve.sv @@
// Top level of the terminal cell color resolver: handshake, configuration
// registers, reverse video and glyph flag. Depends on tccr_pkg and tccr_color_pipe.
//
// Takes one cell word per clock while cell_stall is low and returns one result
// word per cell, in order. An accepted cell passes the palette decode and palette
// digits registers before its result is in the output register. The three register
// stages (palette decode, palette digits, selection into the output register)
// each advance whenever the stage after them is empty or moving, so the block
// keeps one word per cycle as long as result_stall stays low and fills its
// stages when it is held. Foreground and background are resolved by kind
// (configured default, direct RGB, or xterm 256 palette); reverse video swaps
// them. Write the default colors only while no cell is in flight.
module terminal_cell_color_resolve import tccr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cell_valid,
  output logic                  cell_stall,
  input  cell_word_t            cell_word,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_word_t          result,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [ColorWidth-1:0] cfg_data
);

  typedef struct packed {
    logic [7:0]           attr;
    logic                 glyph;
    logic                 reverse;
    logic [CodeWidth-1:0] code;
  } side_t;

  logic [ColorWidth-1:0] fg_default;
  logic [ColorWidth-1:0] bg_default;

  logic      v1;
  logic      v2;
  side_t     side1;
  side_t     side2;
  side_t     side_next;
  stage_en_t en;
  logic      ready1;
  logic      ready2;
  logic      ready3;

  logic [ColorWidth-1:0] fg_res;
  logic [ColorWidth-1:0] bg_res;

  always_comb begin
    ready3     = !result_valid || !result_stall;
    ready2     = !v2 || ready3;
    ready1     = !v1 || ready2;
    en.s1      = ready1;
    en.s2      = ready2;
    cell_stall = !ready1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_default <= DefaultFgReset;
      bg_default <= DefaultBgReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEFAULT_FG: fg_default <= cfg_data;
        CFG_DEFAULT_BG: bg_default <= cfg_data;
        default:        fg_default <= fg_default;
      endcase
    end
  end

  always_comb begin
    side_next.attr    = cell_word.attr_low;
    side_next.reverse = cell_word.is_reverse;
    side_next.code    = cell_word.code_point;
    side_next.glyph   = !cell_word.is_wide_tail && !cell_word.is_invisible &&
                        (cell_word.code_point != CodeNull) &&
                        (cell_word.code_point != CodeSpace);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= cell_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        result_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      side1 <= side_next;
    end
    if (ready2) begin
      side2 <= side1;
    end
    if (ready3) begin
      result.fg_color       <= side2.reverse ? bg_res : fg_res;
      result.bg_color       <= side2.reverse ? fg_res : bg_res;
      result.attr_out       <= side2.attr;
      result.glyph_wanted   <= side2.glyph;
      result.code_point_out <= side2.code;
    end
  end

  tccr_color_pipe u_fg (
    .clk    (clk),
    .en     (en),
    .kind   (cell_word.fg_kind),
    .index  (cell_word.fg_index),
    .direct (cell_word.fg_direct),
    .dflt   (fg_default),
    .color  (fg_res)
  );

  tccr_color_pipe u_bg (
    .clk    (clk),
    .en     (en),
    .kind   (cell_word.bg_kind),
    .index  (cell_word.bg_index),
    .direct (cell_word.bg_direct),
    .dflt   (bg_default),
    .color  (bg_res)
  );

endmodule
